>>> hdl/pds_pkg.sv
// shared types and constants for the path dot-segment simplifier
// no dependencies; imported by pds_ctrl, pds_dp and the top level
package pds_pkg;

	localparam int BUF_DEPTH    = 256;
	localparam int MAX_SEGMENTS = 128;
	localparam int BUF_AW       = $clog2(BUF_DEPTH);
	localparam int PTR_W        = BUF_AW + 1;
	localparam int STK_AW       = $clog2(MAX_SEGMENTS);
	localparam int TOP_W        = STK_AW + 1;

	localparam logic [7:0] SLASH_CHAR = 8'h2F;
	localparam logic [7:0] DOT_CHAR   = 8'h2E;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] path_byte;
		logic       path_last;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       out_ready;
		logic       overflow;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic byte_go;
		logic pull_go;
		logic open_seg;
		logic put_char;
		logic end_seg;
		logic pop_load;
		logic finish;
		logic deliver;
	} pds_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic opening;
		logic last;
		logic pop_go;
		logic slot_free;
	} pds_sts_t;

endpackage

>>> hdl/pds_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/pds_ctrl.sv
// sequencing state machine for the path simplifier
// depends on pds_pkg; drives pds_dp through the command struct
module pds_ctrl
	import pds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  req_t     req,
	input  pds_sts_t sts,
	output pds_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_OPEN  = 7'b0000010,
		ST_PUTC  = 7'b0000100,
		ST_SEG   = 7'b0001000,
		ST_POP   = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_PDATA = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req.func == FUNC_PULL) begin
						cmd.pull_go = 1'b1;
						state_d     = ST_PDATA;
					end else begin
						cmd.byte_go = 1'b1;
						if (req.path_byte == SLASH_CHAR) begin
							state_d = ST_SEG;
						end else if (sts.opening) begin
							state_d = ST_OPEN;
						end else begin
							state_d = ST_PUTC;
						end
					end
				end
			end
			ST_OPEN: begin
				cmd.open_seg = 1'b1;
				state_d      = ST_PUTC;
			end
			ST_PUTC: begin
				cmd.put_char = 1'b1;
				state_d      = sts.last ? ST_SEG : ST_IDLE;
			end
			ST_SEG: begin
				cmd.end_seg = 1'b1;
				if (sts.pop_go) begin
					state_d = ST_POP;
				end else begin
					state_d = sts.last ? ST_FIN : ST_IDLE;
				end
			end
			ST_POP: begin
				cmd.pop_load = 1'b1;
				state_d      = sts.last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_PDATA: begin
				// hold the read until the output register can take it
				if (sts.slot_free) begin
					cmd.deliver = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/pds_dp.sv
// datapath of the path simplifier: pointers, segment tracking, output register
// depends on pds_pkg and pds_ram (path buffer and segment stack)
module pds_dp
	import pds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  pds_cmd_t cmd,
	output pds_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rsp_t     rsp
);

	logic [7:0]       byte_q;
	logic             last_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] seg_q;
	logic [1:0]       dot_q;
	logic             other_q;
	logic [TOP_W-1:0] top_q;
	logic             done_q;
	logic             ovf_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic              wp_full;
	logic              seg_empty;
	logic              is_dot1;
	logic              is_dot2;
	logic              seg_in_buf;
	logic              stk_full;
	logic [PTR_W-1:0]  idx;
	logic [PTR_W-1:0]  idx_next;
	logic [TOP_W-1:0]  top_dec;

	logic              buf_we;
	logic [7:0]        buf_wdata;
	logic [7:0]        buf_rdata;
	logic              stk_we;
	logic              stk_re;
	logic [BUF_AW-1:0] stk_rdata;

	assign wp_full    = (wp_q >= PTR_W'(BUF_DEPTH));
	assign seg_empty  = (dot_q == 2'd0) && !other_q;
	assign is_dot1    = !other_q && (dot_q == 2'd1);
	assign is_dot2    = !other_q && (dot_q == 2'd2);
	assign seg_in_buf = (seg_q < PTR_W'(BUF_DEPTH));
	assign stk_full   = (top_q >= TOP_W'(MAX_SEGMENTS));
	assign top_dec    = top_q - TOP_W'(1);
	assign idx        = (rp_q >= wp_q) ? '0 : rp_q;
	assign idx_next   = idx + PTR_W'(1);

	assign sts.opening   = done_q || seg_empty;
	assign sts.last      = last_q;
	assign sts.pop_go    = is_dot2 && (top_q != '0);
	assign sts.slot_free = !rsp_valid_q || rsp_ready;

	assign buf_we    = (cmd.open_seg || cmd.put_char) && !wp_full;
	assign buf_wdata = cmd.open_seg ? SLASH_CHAR : byte_q;
	assign stk_we    = cmd.end_seg && !seg_empty && !is_dot1 && !is_dot2
		&& seg_in_buf && !stk_full;
	assign stk_re    = cmd.end_seg && sts.pop_go;

	pds_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (wp_q[BUF_AW-1:0]),
		.wdata (buf_wdata),
		.re    (cmd.pull_go),
		.raddr (idx[BUF_AW-1:0]),
		.rdata (buf_rdata)
	);

	pds_ram #(
		.WIDTH (BUF_AW),
		.DEPTH (MAX_SEGMENTS)
	) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (top_q[STK_AW-1:0]),
		.wdata (seg_q[BUF_AW-1:0]),
		.re    (stk_re),
		.raddr (top_dec[STK_AW-1:0]),
		.rdata (stk_rdata)
	);

	// incoming transaction fields, held while the byte is worked on
	always_ff @(posedge clk) begin
		if (cmd.byte_go) begin
			byte_q <= req.path_byte;
			last_q <= req.path_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			seg_q   <= '0;
			dot_q   <= '0;
			other_q <= 1'b0;
			top_q   <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			// a path byte after a finished path starts afresh
			if (cmd.byte_go && done_q) begin
				wp_q    <= '0;
				rp_q    <= '0;
				seg_q   <= '0;
				dot_q   <= '0;
				other_q <= 1'b0;
				top_q   <= '0;
				done_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end
			if (cmd.open_seg) begin
				seg_q <= wp_q;
			end
			if (cmd.open_seg || cmd.put_char) begin
				if (wp_full) begin
					ovf_q <= 1'b1;
				end else begin
					wp_q <= wp_q + PTR_W'(1);
				end
			end
			if (cmd.put_char) begin
				if (byte_q == DOT_CHAR) begin
					if (dot_q != 2'd3) begin
						dot_q <= dot_q + 2'd1;
					end
				end else begin
					other_q <= 1'b1;
				end
			end
			if (cmd.end_seg && !seg_empty) begin
				if (is_dot1) begin
					wp_q <= seg_q;
				end else if (is_dot2) begin
					wp_q <= seg_q;
					if (top_q != '0) begin
						top_q <= top_dec;
					end
				end else if (seg_in_buf) begin
					if (!stk_full) begin
						top_q <= top_q + TOP_W'(1);
					end else begin
						// no room to keep the segment: roll its bytes back
						wp_q  <= seg_q;
						ovf_q <= 1'b1;
					end
				end
				dot_q   <= '0;
				other_q <= 1'b0;
			end
			if (cmd.pop_load) begin
				wp_q <= {1'b0, stk_rdata};
			end
			if (cmd.finish) begin
				done_q <= 1'b1;
				rp_q   <= '0;
			end
			if (cmd.deliver && done_q) begin
				if (wp_q == '0 || idx_next >= wp_q) begin
					rp_q <= '0;
				end else begin
					rp_q <= idx_next;
				end
			end
		end
	end

	// output register, refilled only when the downstream side has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			rsp_q.overflow <= ovf_q;
			if (!done_q) begin
				rsp_q.out_byte  <= '0;
				rsp_q.out_last  <= 1'b0;
				rsp_q.out_ready <= 1'b0;
			end else if (wp_q == '0) begin
				rsp_q.out_byte  <= SLASH_CHAR;
				rsp_q.out_last  <= 1'b1;
				rsp_q.out_ready <= 1'b1;
			end else begin
				rsp_q.out_byte  <= buf_rdata;
				rsp_q.out_last  <= (idx_next >= wp_q);
				rsp_q.out_ready <= 1'b1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hdl/path_dot_segment_simplifier.sv
// top level of the unix path simplifier
// depends on pds_pkg, pds_ctrl, pds_dp (which holds two pds_ram instances)

// A path enters one byte per transaction (func 0), with path_last on its final
// byte; slash runs and "." segments are dropped, ".." pops the last kept
// segment, and the canonical text is built in a 256-byte buffer with a
// 128-entry stack of segment starts. A pull transaction (func 1) returns the
// next byte of the canonical path, wrapping to the start after the last one,
// or "/" when nothing is kept, or a not-ready response while a path is open.
// A path byte passes through states in turn: the single buffer write port
// takes a segment's opening slash and the character in separate states, a
// segment end has a state of its own, and a ".." adds one for the registered
// stack read. A pull goes through the registered buffer read, and a new
// transaction is taken while a response still waits in the output register.
module path_dot_segment_simplifier
	import pds_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	pds_cmd_t cmd;
	pds_sts_t sts;

	pds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.sts       (sts),
		.cmd       (cmd)
	);

	pds_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
